// ----- src/bit_extract_then_deposit_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bit extract / deposit block
// Shared property templates: clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef BIT_EXTRACT_THEN_DEPOSIT_TOP_ASSERT_SVH
`define BIT_EXTRACT_THEN_DEPOSIT_TOP_ASSERT_SVH

// same-cycle implication
`define BXD_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bxd: same-cycle check failed");

// next-cycle implication
`define BXD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bxd: next-cycle check failed");

`endif

// ----- src/bxd_pkg.sv -----
// ----------------------------------------------------------------------------
// bxd_pkg
// Constants shared by the bit extract / deposit pipeline and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bxd_pkg;

	// register stages from input transfer to output register
	localparam int unsigned PIPE_STAGES = 4;

	// legal range of the data path width
	localparam int unsigned MIN_WORD_BITS = 8;
	localparam int unsigned MAX_WORD_BITS = 64;

endpackage

`default_nettype wire

// ----- src/bit_extract_then_deposit_top.sv -----
// ----------------------------------------------------------------------------
// bit_extract_then_deposit_top
// Bit gather (PEXT) followed by bit scatter (PDEP), four-stage pipeline.
// ----------------------------------------------------------------------------
// Path: an accepted item passes through stage registers s1, s2, s3 and s4; out_valid
// is the s4 valid bit, and a low out_ready holds the item in its stage.
// Throughput: one item per cycle while out_ready stays high; every stage holds one
// item and the ready chain lets bubbles fill while the output register waits.
// Reset: arst_n clears the stage valid bits only; payload registers are not reset.
`default_nettype none

module bit_extract_then_deposit_top #(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WORD_BITS-1:0] source_value,
	input  logic [WORD_BITS-1:0] gather_mask,
	input  logic [WORD_BITS-1:0] scatter_mask,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] scattered_word
);
	import bxd_pkg::*;

	// A rank is the count of mask bits below a position: 0 .. WORD_BITS-1.
	localparam int unsigned RANK_BITS   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int unsigned SCAN_LEVELS = RANK_BITS;

	typedef logic [RANK_BITS-1:0] rank_t;

	// ------------------------------------------------------------------------
	// Flow control
	// A stage may load when it is empty or when the stage after it loads.
	// The chain is combinational from out_ready back to in_ready.
	// ------------------------------------------------------------------------
	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PIPE_STAGES-1:0] vld;
	logic [PIPE_STAGES-1:0] rdy;

	assign vld = {vld_s4, vld_s3, vld_s2, vld_s1};

	always_comb begin
		rdy[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || out_ready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy[0]) vld_s1 <= in_valid;
			if (rdy[1]) vld_s2 <= vld_s1;
			if (rdy[2]) vld_s3 <= vld_s2;
			if (rdy[3]) vld_s4 <= vld_s3;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: input capture
	// ------------------------------------------------------------------------
	logic [WORD_BITS-1:0] data_s1, gmask_s1, smask_s1;

	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			data_s1  <= source_value;
			gmask_s1 <= gather_mask;
			smask_s1 <= scatter_mask;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1 -> 2: exclusive prefix counts of both masks.
	// Log-depth scan (Kogge-Stone), RANK_BITS levels of narrow adds per lane.
	// ------------------------------------------------------------------------
	rank_t gscan [SCAN_LEVELS+1][WORD_BITS];
	rank_t sscan [SCAN_LEVELS+1][WORD_BITS];

	always_comb begin
		// level 0: each lane holds the mask bit just below it
		gscan[0][0] = '0;
		sscan[0][0] = '0;
		for (int i = 1; i < WORD_BITS; i++) begin
			gscan[0][i] = rank_t'(gmask_s1[i-1]);
			sscan[0][i] = rank_t'(smask_s1[i-1]);
		end
		for (int l = 0; l < SCAN_LEVELS; l++) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (i >= (1 << l)) begin
					gscan[l+1][i] = gscan[l][i] + gscan[l][i-(1<<l)];
					sscan[l+1][i] = sscan[l][i] + sscan[l][i-(1<<l)];
				end else begin
					gscan[l+1][i] = gscan[l][i];
					sscan[l+1][i] = sscan[l][i];
				end
			end
		end
	end

	logic [WORD_BITS-1:0] gbits_s2, smask_s2;
	rank_t                grank_s2 [WORD_BITS];
	rank_t                srank_s2 [WORD_BITS];

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy[1]) begin
			gbits_s2 <= data_s1 & gmask_s1;   // unselected bits drop out here
			smask_s2 <= smask_s1;
			for (int i = 0; i < WORD_BITS; i++) begin
				grank_s2[i] <= gscan[SCAN_LEVELS][i];
				srank_s2[i] <= sscan[SCAN_LEVELS][i];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2 -> 3: gather. Packed bit k is the selected bit of rank k.
	// Ranks of selected bits are distinct, so an AND-OR is exact.
	// ------------------------------------------------------------------------
	logic [WORD_BITS-1:0] packed_c;

	always_comb begin
		packed_c = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			for (int i = k; i < WORD_BITS; i++) begin
				packed_c[k] = packed_c[k] | (gbits_s2[i] && (grank_s2[i] == rank_t'(k)));
			end
		end
	end

	logic [WORD_BITS-1:0] packed_s3, smask_s3;
	rank_t                srank_s3 [WORD_BITS];

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy[2]) begin
			packed_s3 <= packed_c;
			smask_s3  <= smask_s2;
			for (int i = 0; i < WORD_BITS; i++) begin
				srank_s3[i] <= srank_s2[i];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 3 -> 4: scatter. A set scatter position j takes packed bit of
	// its rank; rank never exceeds j, so the select stays in range.
	// ------------------------------------------------------------------------
	logic [WORD_BITS-1:0] word_c;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			word_c[j] = smask_s3[j] & packed_s3[srank_s3[j]];
		end
	end

	logic [WORD_BITS-1:0] word_s4;

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy[3]) begin
			word_s4 <= word_c;
		end
	end

	// Stage 4 is the output register.
	assign out_valid      = vld_s4;
	assign scattered_word = word_s4;

endmodule

`default_nettype wire

// ----- src/bxd_check.sv -----
// ----------------------------------------------------------------------------
// bxd_check
// Port-level checks for the bit extract / deposit pipeline, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_extract_then_deposit_top_assert.svh"

module bxd_check #(
	parameter int unsigned WORD_BITS = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [WORD_BITS-1:0] source_value,
	input logic [WORD_BITS-1:0] gather_mask,
	input logic [WORD_BITS-1:0] scatter_mask,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [WORD_BITS-1:0] scattered_word
);
	import bxd_pkg::*;

	// a free output side never back-pressures the input
	`BXD_ASSERT_SAME(a_ready_chain, clk, arst_n, out_ready, in_ready)

	// a held result keeps its value
	`BXD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(scattered_word))

	// with the output side free, a transfer shows up after the pipe depth
	`BXD_ASSERT_NEXT(a_latency, clk, arst_n, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

	// pipe comes out of reset empty
	`BXD_ASSERT_SAME(a_reset_empty, clk, arst_n, $rose(arst_n), !out_valid)

endmodule

bind bit_extract_then_deposit_top bxd_check #(.WORD_BITS(WORD_BITS)) u_bxd_check (.*);

`default_nettype wire

// ----- tb/sv/tb_bit_extract_then_deposit_top.sv -----
// ----------------------------------------------------------------------------
// tb_bit_extract_then_deposit_top
// Self-checking bench for the gather-then-scatter pipeline. Directed corner
// items come first, then random items with mixed mask shapes. Both channels
// idle at random. Every result transfer is checked in order against a
// bit-serial model of the gather and scatter steps.
// ----------------------------------------------------------------------------
module tb_bit_extract_then_deposit_top;

	import bxd_pkg::*;

	localparam int unsigned WIDTH        = 64;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned PAUSE_AT     = 200;       // sender drains the pipe here
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 4 * PIPE_STAGES;

	// shapes used to build random masks
	typedef enum int {
		MASK_ZERO,
		MASK_FULL,
		MASK_SPARSE,
		MASK_DENSE,
		MASK_RUN,
		MASK_ONE_HOT,
		MASK_ANY
	} mask_shape_e;

	// ------------------------------------------------------------------
	// Expected-result store plus the gather/scatter model
	// ------------------------------------------------------------------
	class deposit_checker;
		logic [WIDTH-1:0] expected_words[$];
		int unsigned      failures;

		function new();
			failures = 0;
		endfunction

		// gather the gm-selected bits of src to the low end, then place them
		// lowest first onto the set bits of sm; unused sm positions stay zero
		function logic [WIDTH-1:0] gather_scatter(logic [WIDTH-1:0] src,
				logic [WIDTH-1:0] gm, logic [WIDTH-1:0] sm);
			logic [WIDTH-1:0] gathered;
			logic [WIDTH-1:0] placed;
			int unsigned      fill;
			gathered = '0;
			placed   = '0;
			fill     = 0;
			for (int unsigned pos = 0; pos < WIDTH; pos++) begin
				if (gm[pos]) begin
					gathered[fill] = src[pos];
					fill++;
				end
			end
			fill = 0;
			for (int unsigned pos = 0; pos < WIDTH; pos++) begin
				if (sm[pos]) begin
					placed[pos] = gathered[fill];
					fill++;
				end
			end
			return placed;
		endfunction

		function void note_transfer(logic [WIDTH-1:0] src, logic [WIDTH-1:0] gm,
				logic [WIDTH-1:0] sm);
			expected_words.push_back(gather_scatter(src, gm, sm));
		endfunction

		function void check_word(logic [WIDTH-1:0] actual);
			logic [WIDTH-1:0] want;
			if (expected_words.size() == 0) begin
				$error("scattered_word: got %h with nothing expected", actual);
				failures++;
			end else begin
				want = expected_words.pop_front();
				if (actual !== want) begin
					$error("scattered_word: expected %h, actual %h", want, actual);
					failures++;
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_words.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT signals; every input is known from time zero
	// ------------------------------------------------------------------
	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_ready;
	logic [WIDTH-1:0] source_value = '0;
	logic [WIDTH-1:0] gather_mask  = '0;
	logic [WIDTH-1:0] scatter_mask = '0;
	logic             out_valid;
	logic             out_ready    = 1'b0;
	logic [WIDTH-1:0] scattered_word;

	deposit_checker board = new();
	int unsigned    cycles;
	int unsigned    sent;
	int unsigned    taken;

	bit_extract_then_deposit_top #(
		.WORD_BITS(WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_value  (source_value),
		.gather_mask   (gather_mask),
		.scatter_mask  (scatter_mask),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scattered_word(scattered_word)
	);

	// 12-unit clock period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Transfer monitor. Runs in the active region of the edge, so it sees the
	// values that held just before the edge on both channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_transfer(source_value, gather_mask, scatter_mask);
			if (out_valid && out_ready)
				board.check_word(scattered_word);
		end
	end

	// hard stop in case the pipe hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bit_extract_then_deposit_top: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [WIDTH-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [WIDTH-1:0] random_mask();
		mask_shape_e      shape;
		logic [WIDTH-1:0] ones;
		logic [WIDTH-1:0] lsb;
		int unsigned      lo;
		int unsigned      hi;
		shape = mask_shape_e'($urandom_range(MASK_ZERO, MASK_ANY + 2));
		ones  = '1;
		lsb   = {{(WIDTH-1){1'b0}}, 1'b1};
		lo    = $urandom_range(0, WIDTH - 1);
		hi    = $urandom_range(lo, WIDTH - 1);
		case (shape)
			MASK_ZERO:    return '0;
			MASK_FULL:    return ones;
			MASK_SPARSE:  return random_word() & random_word() & random_word();
			MASK_DENSE:   return random_word() | random_word() | random_word();
			MASK_RUN:     return (ones << lo) & (ones >> (WIDTH - 1 - hi));
			MASK_ONE_HOT: return lsb << lo;
			default:      return random_word();    // MASK_ANY and its extra weight
		endcase
	endfunction

	// Sender idles every third block of 40 items not at all.
	// Called at the edge where the previous item went across (or after
	// reset); returns at the edge where this one is accepted.
	task automatic send_item(input logic [WIDTH-1:0] src, input logic [WIDTH-1:0] gm,
			input logic [WIDTH-1:0] sm);
		int unsigned gap;
		gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		source_value <= src;
		gather_mask  <= gm;
		scatter_mask <= sm;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Receiver: may stall before each result, with quiet blocks of 50 results.
	task automatic take_results();
		int unsigned stall;
		forever begin
			stall = ((taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [WIDTH-1:0] ones;
		ones   = '1;
		cycles = 0;
		sent   = 0;
		taken  = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			take_results();
		join_none

		// directed corners
		send_item('0, '0, '0);
		send_item(ones, ones, ones);                          // identity
		send_item(ones, '0, ones);                            // empty gather mask
		send_item(ones, ones, '0);                            // empty scatter mask
		send_item('0, ones, ones);
		send_item(64'hA5A5_A5A5_A5A5_A5A5, 64'h0000_0000_0000_00FF, ones); // spare slots
		send_item(64'h1234_5678_9ABC_DEF0, ones, 64'h0000_0000_0000_000F); // dropped bits
		send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h1); // top to bottom
		send_item(64'h1, 64'h1, 64'h8000_0000_0000_0000);                   // bottom to top
		send_item(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA);
		send_item(ones, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_item(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
			64'h0000_0001_8000_0000);
		send_item(ones, ones, 64'h8000_0000_0000_0000);
		send_item(64'hDEAD_BEEF_CAFE_F00D, 64'h0000_FFFF_FFFF_0000,
			64'hFFFF_FFFF_0000_0000);
		send_item(64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000,
			64'h0000_0001_0000_0000);
		send_item(64'h7FFF_FFFF_FFFF_FFFE, ones, ones);
		send_item(64'hF0F0_F0F0_0F0F_0F0F, 64'hFF00_FF00_FF00_FF00,
			64'h00FF_00FF_00FF_00FF);

		// random part
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				// hold off until the pipe is empty, then carry on
				in_valid <= 1'b0;
				do @(posedge clk); while (board.outstanding() != 0);
			end
			send_item(random_word(), random_mask(), random_mask());
		end

		// wind down: wait for the last results, then look for strays
		in_valid <= 1'b0;
		do @(posedge clk); while (board.outstanding() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.failures == 0)
			$display("tb_bit_extract_then_deposit_top: done, clean");
		else
			$display("tb_bit_extract_then_deposit_top: done, errors");
		$finish;
	end

endmodule
